/* rtl/wpg_pkg.sv */
// Package for the waypoint guidance unit: word types, register codes, fixed-point
// constants and the CORDIC arctangent table. Depends on nothing.
package wpg_pkg;

	// Word formats on the two channels.
	typedef struct packed {
		logic signed [31:0] position_east;
		logic signed [31:0] position_north;
	} wpg_in_t;

	typedef struct packed {
		logic [15:0]        bearing;
		logic [32:0]        range_to_target;
		logic signed [7:0]  speed_command;
		logic               reached;
	} wpg_out_t;

	// Configuration port.
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WAYPOINT_EAST,
		REG_WAYPOINT_NORTH,
		REG_ACCEPT_RADIUS,
		REG_COMMANDED_SPEED
	} wpg_reg_t;

	localparam logic [19:0]       RADIUS_RESET  = 20'd500;
	localparam logic signed [7:0] SPEED_CRUISE  = 8'sd70;
	localparam logic signed [7:0] SPEED_ARRIVED = -8'sd5;

	// Job issued to both datapaths, and their status words.
	typedef struct packed {
		logic               start;
		logic signed [32:0] dx;
		logic signed [32:0] dy;
	} wpg_job_t;

	typedef struct packed {
		logic        done;
		logic [15:0] bearing;
	} wpg_brg_stat_t;

	typedef struct packed {
		logic        done;
		logic        near;
		logic [32:0] range_cm;
	} wpg_rng_stat_t;

	// Angles are radians in signed Q60.
	localparam int unsigned       CORDIC_STEPS_DEF = 32;
	localparam int unsigned       ATAN_IDX_W       = 6;
	localparam logic [63:0]       PI_Q60           = 64'h3243F6A8885A308D;
	localparam logic signed [63:0] TWO_PI_Q60      = $signed(PI_Q60 << 1);

	// Bearing scaling: floor((z_q40 * 18000 + pi_q40 / 2) / pi_q40), then wrap.
	localparam int unsigned QUO_W          = 16;
	localparam int unsigned SCL_W          = 58;
	localparam logic [14:0] BEARING_SCALE  = 15'd18000;
	localparam logic [15:0] BEARING_WRAP   = 16'd36000;
	localparam logic [SCL_W-1:0] PI_Q40      = SCL_W'(PI_Q60 >> 20);
	localparam logic [SCL_W-1:0] HALF_PI_Q40 = PI_Q40 >> 1;
	localparam logic [SCL_W-1:0] DIV_START   = PI_Q40 << (QUO_W - 1);

	// atan(2^-i) in Q60, from the alternating series sum of 2^(60-e)/k, truncated per term.
	localparam logic [63:0] ONE = 64'd1;
	localparam logic [63:0] ATAN_0 = PI_Q60 >> 2;
	localparam logic [63:0] ATAN_1 =
		(ONE<<59) - (ONE<<57)/3 + (ONE<<55)/5 - (ONE<<53)/7 + (ONE<<51)/9
		- (ONE<<49)/11 + (ONE<<47)/13 - (ONE<<45)/15 + (ONE<<43)/17 - (ONE<<41)/19
		+ (ONE<<39)/21 - (ONE<<37)/23 + (ONE<<35)/25 - (ONE<<33)/27 + (ONE<<31)/29
		- (ONE<<29)/31 + (ONE<<27)/33 - (ONE<<25)/35 + (ONE<<23)/37 - (ONE<<21)/39
		+ (ONE<<19)/41 - (ONE<<17)/43 + (ONE<<15)/45 - (ONE<<13)/47 + (ONE<<11)/49
		- (ONE<<9)/51 + (ONE<<7)/53 - (ONE<<5)/55 + (ONE<<3)/57 - (ONE<<1)/59;
	localparam logic [63:0] ATAN_2 =
		(ONE<<58) - (ONE<<54)/3 + (ONE<<50)/5 - (ONE<<46)/7 + (ONE<<42)/9
		- (ONE<<38)/11 + (ONE<<34)/13 - (ONE<<30)/15 + (ONE<<26)/17 - (ONE<<22)/19
		+ (ONE<<18)/21 - (ONE<<14)/23 + (ONE<<10)/25 - (ONE<<6)/27 + (ONE<<2)/29;
	localparam logic [63:0] ATAN_3 =
		(ONE<<57) - (ONE<<51)/3 + (ONE<<45)/5 - (ONE<<39)/7 + (ONE<<33)/9
		- (ONE<<27)/11 + (ONE<<21)/13 - (ONE<<15)/15 + (ONE<<9)/17 - (ONE<<3)/19;
	localparam logic [63:0] ATAN_4 =
		(ONE<<56) - (ONE<<48)/3 + (ONE<<40)/5 - (ONE<<32)/7 + (ONE<<24)/9
		- (ONE<<16)/11 + (ONE<<8)/13 - ONE/15;
	localparam logic [63:0] ATAN_5 =
		(ONE<<55) - (ONE<<45)/3 + (ONE<<35)/5 - (ONE<<25)/7 + (ONE<<15)/9 - (ONE<<5)/11;
	localparam logic [63:0] ATAN_6 =
		(ONE<<54) - (ONE<<42)/3 + (ONE<<30)/5 - (ONE<<18)/7 + (ONE<<6)/9;
	localparam logic [63:0] ATAN_7 = (ONE<<53) - (ONE<<39)/3 + (ONE<<25)/5 - (ONE<<11)/7;
	localparam logic [63:0] ATAN_8 = (ONE<<52) - (ONE<<36)/3 + (ONE<<20)/5 - (ONE<<4)/7;
	localparam logic [63:0] ATAN_9  = (ONE<<51) - (ONE<<33)/3 + (ONE<<15)/5;
	localparam logic [63:0] ATAN_10 = (ONE<<50) - (ONE<<30)/3 + (ONE<<10)/5;
	localparam logic [63:0] ATAN_11 = (ONE<<49) - (ONE<<27)/3 + (ONE<<5)/5;
	localparam logic [63:0] ATAN_12 = (ONE<<48) - (ONE<<24)/3 + ONE/5;
	localparam logic [63:0] ATAN_13 = (ONE<<47) - (ONE<<21)/3;
	localparam logic [63:0] ATAN_14 = (ONE<<46) - (ONE<<18)/3;
	localparam logic [63:0] ATAN_15 = (ONE<<45) - (ONE<<15)/3;
	localparam logic [63:0] ATAN_16 = (ONE<<44) - (ONE<<12)/3;
	localparam logic [63:0] ATAN_17 = (ONE<<43) - (ONE<<9)/3;
	localparam logic [63:0] ATAN_18 = (ONE<<42) - (ONE<<6)/3;
	localparam logic [63:0] ATAN_19 = (ONE<<41) - (ONE<<3)/3;
	localparam logic [63:0] ATAN_20 = (ONE<<40) - ONE/3;

	// Beyond step 20 only the leading term survives; beyond 60 it is zero.
	function automatic logic [63:0] atan_q60(input logic [ATAN_IDX_W-1:0] idx);
		logic [63:0] val;
		case (idx)
			6'd0:    val = ATAN_0;
			6'd1:    val = ATAN_1;
			6'd2:    val = ATAN_2;
			6'd3:    val = ATAN_3;
			6'd4:    val = ATAN_4;
			6'd5:    val = ATAN_5;
			6'd6:    val = ATAN_6;
			6'd7:    val = ATAN_7;
			6'd8:    val = ATAN_8;
			6'd9:    val = ATAN_9;
			6'd10:   val = ATAN_10;
			6'd11:   val = ATAN_11;
			6'd12:   val = ATAN_12;
			6'd13:   val = ATAN_13;
			6'd14:   val = ATAN_14;
			6'd15:   val = ATAN_15;
			6'd16:   val = ATAN_16;
			6'd17:   val = ATAN_17;
			6'd18:   val = ATAN_18;
			6'd19:   val = ATAN_19;
			6'd20:   val = ATAN_20;
			default: val = (idx > 6'd60) ? 64'd0 : (ONE << (6'd60 - idx));
		endcase
		return val;
	endfunction

endpackage

/* rtl/wpg_bearing.sv */
// Bearing datapath: normalization, iterative vectoring CORDIC, serial scaling to
// hundredths of a degree and serial division by pi. Depends on wpg_pkg.
module wpg_bearing #(
	parameter int unsigned CORDIC_STEPS = wpg_pkg::CORDIC_STEPS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  wpg_pkg::wpg_job_t      job,
	output wpg_pkg::wpg_brg_stat_t stat
);
	import wpg_pkg::*;

	localparam int unsigned STEP_W = $clog2(CORDIC_STEPS);

	typedef enum logic [2:0] {
		B_IDLE, B_NORM, B_ROT, B_ADJ, B_SCALE, B_DIV, B_WRAP
	} bstate_t;

	bstate_t                st_q;
	logic [58:0]            ax_q, by_q, mx_q;
	logic                   yneg_q, dyneg_q;
	logic signed [61:0]     x_q, y_q;
	logic signed [63:0]     z_q;
	logic [STEP_W-1:0]      step_q;
	logic [SCL_W-1:0]       mcand_q, acc_q, dv_q;
	logic [14:0]            mbits_q;
	logic [QUO_W-1:0]       q_q;
	logic [3:0]             dcnt_q;
	logic                   done_q;
	logic [15:0]            bearing_q;

	logic signed [32:0]     neg_dx, neg_dy;
	logic [31:0]            abs_x, abs_y, abs_max;
	logic signed [61:0]     xs, ys, ax_ext;
	logic signed [63:0]     atan_i, z_pos;
	logic                   div_ge;

	always_comb begin
		neg_dx  = -job.dx;
		neg_dy  = -job.dy;
		abs_x   = job.dx[32] ? neg_dx[31:0] : job.dx[31:0];
		abs_y   = job.dy[32] ? neg_dy[31:0] : job.dy[31:0];
		abs_max = (abs_x > abs_y) ? abs_x : abs_y;
		xs      = x_q >>> step_q;
		ys      = y_q >>> step_q;
		ax_ext  = $signed({3'b000, ax_q});
		atan_i  = $signed(atan_q60(ATAN_IDX_W'(step_q)));
		z_pos   = z_q[63] ? (z_q + TWO_PI_Q60) : z_q;
		div_ge  = (acc_q >= dv_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= B_IDLE;
			ax_q      <= '0;
			by_q      <= '0;
			mx_q      <= '0;
			yneg_q    <= 1'b0;
			dyneg_q   <= 1'b0;
			x_q       <= '0;
			y_q       <= '0;
			z_q       <= '0;
			step_q    <= '0;
			mcand_q   <= '0;
			acc_q     <= '0;
			dv_q      <= '0;
			mbits_q   <= '0;
			q_q       <= '0;
			dcnt_q    <= '0;
			done_q    <= 1'b0;
			bearing_q <= '0;
		end else if (job.start) begin
			done_q  <= 1'b0;
			ax_q    <= {abs_x, 27'd0};
			by_q    <= {abs_y, 27'd0};
			mx_q    <= {abs_max, 27'd0};
			yneg_q  <= (job.dx[32] != job.dy[32]) && (job.dx != '0);
			dyneg_q <= job.dy[32];
			q_q     <= '0;
			// A zero vector has bearing zero and skips the whole angle path.
			st_q    <= (abs_max == '0) ? B_WRAP : B_NORM;
		end else begin
			case (st_q)
				B_NORM: begin
					if (mx_q[58]) begin
						x_q    <= $signed({3'b000, by_q});
						y_q    <= yneg_q ? -ax_ext : ax_ext;
						z_q    <= dyneg_q ? $signed(PI_Q60) : 64'sd0;
						step_q <= '0;
						st_q   <= B_ROT;
					end else if (mx_q[58:51] == '0) begin
						ax_q <= ax_q << 8;
						by_q <= by_q << 8;
						mx_q <= mx_q << 8;
					end else begin
						ax_q <= ax_q << 1;
						by_q <= by_q << 1;
						mx_q <= mx_q << 1;
					end
				end
				B_ROT: begin
					if (!y_q[61]) begin
						x_q <= x_q + ys;
						y_q <= y_q - xs;
						z_q <= z_q + atan_i;
					end else begin
						x_q <= x_q - ys;
						y_q <= y_q + xs;
						z_q <= z_q - atan_i;
					end
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(CORDIC_STEPS - 1)) begin
						st_q <= B_ADJ;
					end
				end
				B_ADJ: begin
					mcand_q <= SCL_W'(z_pos[62:20]);
					acc_q   <= HALF_PI_Q40;
					mbits_q <= BEARING_SCALE;
					st_q    <= B_SCALE;
				end
				B_SCALE: begin
					if (mbits_q != '0) begin
						if (mbits_q[0]) begin
							acc_q <= acc_q + mcand_q;
						end
						mcand_q <= mcand_q << 1;
						mbits_q <= mbits_q >> 1;
					end else begin
						dv_q   <= DIV_START;
						dcnt_q <= '0;
						q_q    <= '0;
						st_q   <= B_DIV;
					end
				end
				B_DIV: begin
					if (div_ge) begin
						acc_q <= acc_q - dv_q;
					end
					q_q    <= {q_q[QUO_W-2:0], div_ge};
					dv_q   <= dv_q >> 1;
					dcnt_q <= dcnt_q + 1'b1;
					if (dcnt_q == 4'(QUO_W - 1)) begin
						st_q <= B_WRAP;
					end
				end
				B_WRAP: begin
					bearing_q <= (q_q >= BEARING_WRAP) ? (q_q - BEARING_WRAP) : q_q;
					done_q    <= 1'b1;
					st_q      <= B_IDLE;
				end
				default: begin
					st_q <= B_IDLE;
				end
			endcase
		end
	end

	assign stat.done    = done_q;
	assign stat.bearing = bearing_q;

endmodule

/* rtl/wpg_range.sv */
// Range datapath: bit-serial squares of the offsets and the acceptance radius,
// then a two-bit-per-step integer square root. Depends on wpg_pkg.
module wpg_range (
	input  logic                   clk,
	input  logic                   arst_n,
	input  wpg_pkg::wpg_job_t      job,
	input  logic [19:0]            radius,
	output wpg_pkg::wpg_rng_stat_t stat
);
	import wpg_pkg::*;

	localparam int unsigned SQ_STEPS   = 32;
	localparam int unsigned SQRT_STEPS = 33;
	localparam int unsigned CNT_W      = $clog2(SQRT_STEPS);

	typedef enum logic [1:0] {R_IDLE, R_SQ, R_CMP, R_SQRT} rstate_t;

	rstate_t            st_q;
	logic [31:0]        ma_q, mb_q;
	logic [63:0]        pa_q, pb_q;
	logic [19:0]        mr_q;
	logic [39:0]        pr_q, racc_q;
	logic [64:0]        acc_q;
	logic [65:0]        rad_q;
	logic [33:0]        rem_q;
	logic [32:0]        root_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               done_q, near_q;
	logic [32:0]        range_q;

	logic signed [32:0] neg_dx, neg_dy;
	logic [31:0]        abs_x, abs_y;
	logic [35:0]        trial_in, trial;
	logic               sq_ge;

	always_comb begin
		neg_dx   = -job.dx;
		neg_dy   = -job.dy;
		abs_x    = job.dx[32] ? neg_dx[31:0] : job.dx[31:0];
		abs_y    = job.dy[32] ? neg_dy[31:0] : job.dy[31:0];
		trial_in = {rem_q, rad_q[65:64]};
		trial    = {1'b0, root_q, 2'b01};
		sq_ge    = (trial_in >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= R_IDLE;
			ma_q    <= '0;
			mb_q    <= '0;
			pa_q    <= '0;
			pb_q    <= '0;
			mr_q    <= '0;
			pr_q    <= '0;
			racc_q  <= '0;
			acc_q   <= '0;
			rad_q   <= '0;
			rem_q   <= '0;
			root_q  <= '0;
			cnt_q   <= '0;
			done_q  <= 1'b0;
			near_q  <= 1'b0;
			range_q <= '0;
		end else if (job.start) begin
			done_q <= 1'b0;
			ma_q   <= abs_x;
			mb_q   <= abs_y;
			pa_q   <= {32'd0, abs_x};
			pb_q   <= {32'd0, abs_y};
			mr_q   <= radius;
			pr_q   <= {20'd0, radius};
			acc_q  <= '0;
			racc_q <= '0;
			cnt_q  <= '0;
			st_q   <= R_SQ;
		end else begin
			case (st_q)
				R_SQ: begin
					acc_q  <= acc_q + (ma_q[0] ? {1'b0, pa_q} : 65'd0)
						+ (mb_q[0] ? {1'b0, pb_q} : 65'd0);
					racc_q <= racc_q + (mr_q[0] ? pr_q : 40'd0);
					ma_q   <= ma_q >> 1;
					mb_q   <= mb_q >> 1;
					mr_q   <= mr_q >> 1;
					pa_q   <= pa_q << 1;
					pb_q   <= pb_q << 1;
					pr_q   <= pr_q << 1;
					cnt_q  <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(SQ_STEPS - 1)) begin
						st_q <= R_CMP;
					end
				end
				R_CMP: begin
					near_q <= (acc_q < {25'd0, racc_q});
					rad_q  <= {1'b0, acc_q};
					rem_q  <= '0;
					root_q <= '0;
					cnt_q  <= '0;
					st_q   <= R_SQRT;
				end
				R_SQRT: begin
					rem_q  <= sq_ge ? 34'(trial_in - trial) : trial_in[33:0];
					root_q <= {root_q[31:0], sq_ge};
					rad_q  <= rad_q << 2;
					cnt_q  <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(SQRT_STEPS - 1)) begin
						range_q <= {root_q[31:0], sq_ge};
						done_q  <= 1'b1;
						st_q    <= R_IDLE;
					end
				end
				default: begin
					st_q <= R_IDLE;
				end
			endcase
		end
	end

	assign stat.done     = done_q;
	assign stat.near     = near_q;
	assign stat.range_cm = range_q;

endmodule

/* rtl/waypoint_heading_range_guidance_unit.sv */
// A result is registered once both the bearing and the range path report done and the output
// register can take it. A zero offset skips the angle path of the bearing datapath, and a
// stalled output delays the result. The unit takes one word at a time; the next word can be
// taken in the cycle after a result is registered.
// Reset (arst_n low, asynchronous): waypoint 0,0, radius 500, commanded speed 0,
// speed state 0, reached flag clear, no result pending.
module waypoint_heading_range_guidance_unit #(
	parameter int unsigned CORDIC_STEPS = wpg_pkg::CORDIC_STEPS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  wpg_pkg::wpg_in_t                   in_data,
	output logic                               out_valid,
	input  logic                               out_stall,
	output wpg_pkg::wpg_out_t                  out_data,
	input  logic                               cfg_wr_en,
	input  logic [wpg_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [wpg_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import wpg_pkg::*;

	// The unit handles one position word at a time. IDLE takes a word and latches the
	// offset to the waypoint, START launches both datapaths, WAIT holds until both
	// report done and the output register can take the result.
	typedef enum logic [1:0] {ST_IDLE, ST_START, ST_WAIT} state_t;

	state_t              state_q;
	logic signed [31:0]  wp_east_q, wp_north_q;
	logic [19:0]         radius_q;
	logic signed [7:0]   cmd_speed_q, speed_q;
	logic                reached_q;
	logic signed [32:0]  dx_q, dy_q;
	logic                out_valid_q;
	wpg_out_t            out_data_q;

	wpg_job_t            job;
	wpg_brg_stat_t       brg_stat;
	wpg_rng_stat_t       rng_stat;

	logic                in_take, finish;
	logic signed [7:0]   speed_pre, speed_new;
	logic                reached_new;

	// Offsets are formed at 33 bits so that no waypoint/position pair can overflow.
	always_comb begin
		in_take     = in_valid && (state_q == ST_IDLE);
		finish      = (state_q == ST_WAIT) && brg_stat.done && rng_stat.done
			&& (!out_valid_q || !out_stall);
		// A stopped vehicle that has not yet arrived is sent off at cruise speed first;
		// arriving inside the acceptance radius then overrides that with the hold speed.
		speed_pre   = ((speed_q == 8'sd0) && !reached_q) ? SPEED_CRUISE : speed_q;
		speed_new   = rng_stat.near ? SPEED_ARRIVED : speed_pre;
		reached_new = reached_q || rng_stat.near;
		job.start   = (state_q == ST_START);
		job.dx      = dx_q;
		job.dy      = dy_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wp_east_q   <= '0;
			wp_north_q  <= '0;
			radius_q    <= RADIUS_RESET;
			cmd_speed_q <= '0;
			speed_q     <= '0;
			reached_q   <= 1'b0;
			dx_q        <= '0;
			dy_q        <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			// The user must write configuration only while the unit is idle; it is not enforced.
			// Every write re-arms the waypoint: reached flag clears, speed reloads from the command.
			if (cfg_wr_en) begin
				case (wpg_reg_t'(cfg_index))
					REG_WAYPOINT_EAST:   wp_east_q   <= $signed(cfg_data);
					REG_WAYPOINT_NORTH:  wp_north_q  <= $signed(cfg_data);
					REG_ACCEPT_RADIUS:   radius_q    <= cfg_data[19:0];
					REG_COMMANDED_SPEED: cmd_speed_q <= $signed(cfg_data[7:0]);
					default: ;
				endcase
				reached_q <= 1'b0;
				speed_q   <= (wpg_reg_t'(cfg_index) == REG_COMMANDED_SPEED)
					? $signed(cfg_data[7:0]) : cmd_speed_q;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						dx_q    <= {wp_east_q[31], wp_east_q}
							- {in_data.position_east[31], in_data.position_east};
						dy_q    <= {wp_north_q[31], wp_north_q}
							- {in_data.position_north[31], in_data.position_north};
						state_q <= ST_START;
					end
				end
				ST_START: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (finish) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// The output register decouples the two sides: a finished result may wait here
			// while the next position word is already being worked on.
			if (finish) begin
				speed_q                    <= speed_new;
				reached_q                  <= reached_new;
				out_valid_q                <= 1'b1;
				out_data_q.bearing         <= brg_stat.bearing;
				out_data_q.range_to_target <= rng_stat.range_cm;
				out_data_q.speed_command   <= speed_new;
				out_data_q.reached         <= reached_new;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Bearing: normalize, rotate CORDIC_STEPS times, then scale and divide serially.
	wpg_bearing #(
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_bearing (
		.clk    (clk),
		.arst_n (arst_n),
		.job    (job),
		.stat   (brg_stat)
	);

	// Range: serial squares and radius check, then a serial square root.
	wpg_range u_range (
		.clk    (clk),
		.arst_n (arst_n),
		.job    (job),
		.radius (radius_q),
		.stat   (rng_stat)
	);

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// A taken word always launches the datapaths in the following cycle.
	a_take_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == ST_START))
		else $error("accepted word did not launch the datapaths");

	// A launch must withdraw the done status of the previous word in both datapaths.
	a_start_clears_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_START) |=> (!brg_stat.done && !rng_stat.done))
		else $error("stale done status after launch");

	// Once the waypoint is reached the speed stays at the hold value until re-armed.
	a_reached_speed: assert property (@(posedge clk) disable iff (!arst_n)
		reached_q |-> (speed_q == SPEED_ARRIVED))
		else $error("reached flag set without hold speed");

	// The wrap step keeps every registered bearing inside one turn.
	a_bearing_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_data_q.bearing < BEARING_WRAP))
		else $error("bearing outside one turn");

endmodule
